@@ design/gre_hp_pkg.sv @@
// shared types, flag masks and header-length helpers for the gre header parser
`default_nettype none
package gre_hp_pkg;

  localparam logic [15:0] FlagChecksum  = 16'h8000;
  localparam logic [15:0] FlagRouting   = 16'h4000;
  localparam logic [15:0] FlagKey       = 16'h2000;
  localparam logic [15:0] FlagSequence  = 16'h1000;
  localparam logic [15:0] FlagAck       = 16'h0080;
  localparam logic [15:0] VersionMask   = 16'h0007;
  localparam logic [15:0] VersionPptp   = 16'h0001;
  localparam logic [15:0] TypeErspan    = 16'h88be;
  localparam logic [15:0] EthCodeReset  = 16'd65530;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] payload_offset;
    logic [15:0] payload_type;
  } res_item_t;

  function automatic logic is_pptp(input logic [15:0] flags);
    is_pptp = (flags & VersionMask) == VersionPptp;
  endfunction

  function automatic logic has_routing(input logic [15:0] flags);
    has_routing = !is_pptp(flags) && ((flags & FlagRouting) != 16'h0);
  endfunction

  // bytes of optional words after the type field
  function automatic logic [7:0] fixed_skip(input logic [15:0] flags);
    logic [7:0] n;
    n = 8'd0;
    if (is_pptp(flags)) begin
      n = 8'd4;
      if ((flags & FlagSequence) != 16'h0) n = n + 8'd4;
      if ((flags & FlagAck) != 16'h0) n = n + 8'd4;
    end else begin
      if ((flags & (FlagChecksum | FlagRouting)) != 16'h0) n = n + 8'd4;
      if ((flags & FlagKey) != 16'h0) n = n + 8'd4;
      if ((flags & FlagSequence) != 16'h0) n = n + 8'd4;
    end
    fixed_skip = n;
  endfunction

endpackage
`default_nettype wire

@@ design/gre_hp_if.sv @@
// valid/ready channel interfaces for packet bytes and parse results
`default_nettype none
interface gre_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gre_hp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [15:0] payload_offset;
  logic [15:0] payload_type;

  modport source (output valid, output status, output payload_offset,
                  output payload_type, input ready);
  modport sink (input valid, input status, input payload_offset,
                input payload_type, output ready);
endinterface
`default_nettype wire

@@ design/gre_hp_parser.sv @@
// per-packet parse state and the one-byte step of the header walk
`default_nettype none
module gre_hp_parser #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     step_i,
  input  gre_hp_pkg::in_item_t    item_i,
  input  wire  [15:0]             eth_code_i,
  output logic                    res_valid_o,
  output gre_hp_pkg::res_item_t   res_o
);
  import gre_hp_pkg::*;

  localparam logic [15:0] OffsetLimit = (OFFSET_WIDTH >= 16) ? 16'hFFFF :
                                        16'((64'd1 << OFFSET_WIDTH) - 64'd1);

  localparam logic [2:0] PH_FLAGS_HI = 3'd0;
  localparam logic [2:0] PH_FLAGS_LO = 3'd1;
  localparam logic [2:0] PH_TYPE_HI  = 3'd2;
  localparam logic [2:0] PH_TYPE_LO  = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;
  localparam logic [2:0] PH_SRE_HEAD = 3'd5;
  localparam logic [2:0] PH_SRE_LEN  = 3'd6;
  localparam logic [2:0] PH_SRE_BODY = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] flags_q, flags_d;
  logic [15:0] type_q, type_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  skip_q, skip_d;
  logic        done_q, done_d;
  logic        complete;
  logic        clear_pkt;
  logic [7:0]  skip_dec;

  assign skip_dec = skip_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    type_d      = type_q;
    pos_d       = pos_q;
    skip_d      = skip_q;
    done_d      = done_q;
    complete    = 1'b0;
    clear_pkt   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (done_q) begin
        // header already reported, drop bytes until the packet ends
        clear_pkt = item_i.last_byte;
      end else if (pos_q >= OffsetLimit) begin
        res_valid_o   = 1'b1;
        res_o.status  = 1'b1;
        clear_pkt     = item_i.last_byte;
        done_d        = 1'b1;
      end else begin
        pos_d = pos_q + 16'd1;
        unique case (phase_q)
          PH_FLAGS_HI: begin
            flags_d = {item_i.data_byte, 8'h00};
            phase_d = PH_FLAGS_LO;
          end
          PH_FLAGS_LO: begin
            flags_d = {flags_q[15:8], item_i.data_byte};
            phase_d = PH_TYPE_HI;
          end
          PH_TYPE_HI: begin
            type_d  = {item_i.data_byte, 8'h00};
            phase_d = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_d = {type_q[15:8], item_i.data_byte};
            skip_d = fixed_skip(flags_q);
            if (skip_d != 8'd0) begin
              phase_d = PH_SKIP;
            end else if (has_routing(flags_q)) begin
              phase_d = PH_SRE_HEAD;
              skip_d  = 8'd3;
            end else begin
              complete = 1'b1;
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == 8'd0) begin
              if (has_routing(flags_q)) begin
                phase_d = PH_SRE_HEAD;
                skip_d  = 8'd3;
              end else begin
                complete = 1'b1;
              end
            end
          end
          PH_SRE_HEAD: begin
            skip_d = skip_dec;
            if (skip_dec == 8'd0) phase_d = PH_SRE_LEN;
          end
          PH_SRE_LEN: begin
            if (item_i.data_byte == 8'd0) begin
              complete = 1'b1;
            end else begin
              skip_d  = item_i.data_byte;
              phase_d = PH_SRE_BODY;
            end
          end
          PH_SRE_BODY: begin
            skip_d = skip_dec;
            if (skip_dec == 8'd0) begin
              phase_d = PH_SRE_HEAD;
              skip_d  = 8'd3;
            end
          end
        endcase
        if (complete) begin
          res_valid_o          = 1'b1;
          res_o.status         = 1'b0;
          res_o.payload_offset = pos_d;
          // erspan type i without sequence carries bare ethernet
          res_o.payload_type   = (type_d == TypeErspan &&
                                  (flags_q & FlagSequence) == 16'h0) ?
                                 eth_code_i : type_d;
          done_d               = 1'b1;
          clear_pkt            = item_i.last_byte;
        end else if (item_i.last_byte) begin
          res_valid_o  = 1'b1;
          res_o.status = 1'b1;
          clear_pkt    = 1'b1;
        end
      end
    end
    if (clear_pkt) begin
      phase_d = PH_FLAGS_HI;
      flags_d = '0;
      type_d  = '0;
      pos_d   = '0;
      skip_d  = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAGS_HI;
      flags_q <= '0;
      type_q  <= '0;
      pos_q   <= '0;
      skip_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      type_q  <= type_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
      done_q  <= done_d;
    end
  end

endmodule
`default_nettype wire

@@ design/gre_header_parser.sv @@
// gre header parser top level: input register, parse step, result register
//
// usage:
//   in_i carries one packet byte per transfer (data_byte, last_byte marks the
//   final byte of a packet). out_o gives one result per packet: status 0 with
//   payload_offset (header length in bytes) and payload_type, or status 1
//   with zero offset and type when the packet ends inside the header or the
//   header runs past the offset limit. cfg_we_i/cfg_wdata_i write the type
//   code reported for erspan type i payloads; write it only while idle.
//   throughput: one byte per cycle while out_o is not stalled; the parse step is
//   combinational. each byte's result reaches out_o through two registers,
//   the input register and then the result register.
//   reset clears the parse state and the result register and restores the
//   ethernet type code to 65530.
//   when out_o stalls with a result waiting, the byte in the input register
//   waits as well; in_i ready drops once that register is full and rises
//   again in the cycle the result is taken. nothing is lost or repeated.
`default_nettype none
module gre_header_parser #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  gre_hp_in_if.sink         in_i,
  gre_hp_out_if.source      out_o,
  input  wire               cfg_we_i,
  input  wire  [15:0]       cfg_wdata_i
);
  import gre_hp_pkg::*;

  // configuration register
  logic [15:0] eth_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eth_code_q <= EthCodeReset;
    end else if (cfg_we_i) begin
      eth_code_q <= cfg_wdata_i;
    end
  end

  // input register
  logic      in_vld_q;
  in_item_t  in_item_q;
  logic      in_xfer;
  logic      step;

  // result register
  logic      out_vld_q;
  res_item_t out_item_q;
  logic      res_valid;
  res_item_t res;

  // step the byte when the result register is free or draining this cycle
  assign step       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.data_byte <= in_i.data_byte;
      in_item_q.last_byte <= in_i.last_byte;
    end
  end

  gre_hp_parser #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .eth_code_i  (eth_code_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && res_valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_item_q.status;
  assign out_o.payload_offset = out_item_q.payload_offset;
  assign out_o.payload_type   = out_item_q.payload_type;

  // a corrupt report carries no offset and no type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.status) |->
      (out_item_q.payload_offset == 16'd0 && out_item_q.payload_type == 16'd0))
    else $error("corrupt result with nonzero fields");

  // a good header is at least the flags and type words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_item_q.status) |-> (out_item_q.payload_offset >= 16'd4))
    else $error("ok result shorter than base header");

  // input only stalls behind a held byte that cannot step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without cause");

endmodule
`default_nettype wire

@@ tb/gre_hp_checker.sv @@
// scoreboard for the gre header parser: predicts one result per packet and compares
`timescale 1ns / 100ps
module gre_hp_checker #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gre_hp_in_if        in_mon,
  gre_hp_out_if       out_mon,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          fails_o
);
  import gre_hp_pkg::*;

  localparam int unsigned OffsetLimit =
    (OFFSET_WIDTH >= 16) ? 65535 : (1 << OFFSET_WIDTH) - 1;
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusCorrupt = 1'b1;

  typedef enum logic [3:0] {
    WalkFlagsHi, WalkFlagsLo, WalkTypeHi, WalkTypeLo,
    WalkSkip, WalkSreHead, WalkSreLen, WalkSreBody
  } walk_e;

  walk_e       st;
  logic [15:0] eth_code;
  logic [15:0] flags;
  logic [15:0] ptype;
  logic [15:0] pos;
  logic [7:0]  skip;
  logic        hdr_done;
  res_item_t   expected_q[$];
  res_item_t   want;
  res_item_t   got;
  int          n_fail;

  task automatic clear_walk();
    st       = WalkFlagsHi;
    flags    = '0;
    ptype    = '0;
    pos      = '0;
    skip     = '0;
    hdr_done = 1'b0;
  endtask

  // optional words after the type field, counted in words then scaled to bytes
  function automatic logic [7:0] option_bytes(input logic [15:0] f);
    logic [7:0] words;
    if ((f & VersionMask) == VersionPptp)
      words = 8'd1 + 8'((f & FlagSequence) != 0) + 8'((f & FlagAck) != 0);
    else
      words = 8'((f & (FlagChecksum | FlagRouting)) != 0) + 8'((f & FlagKey) != 0)
            + 8'((f & FlagSequence) != 0);
    return words << 2;
  endfunction

  // end of the optional words: either into the source-route walk or done
  function automatic logic options_finished();
    if ((flags & VersionMask) != VersionPptp && (flags & FlagRouting) != 0) begin
      st   = WalkSreHead;
      skip = 8'd3;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last);
    logic      complete;
    res_item_t r;
    complete = 1'b0;
    if (hdr_done) begin
      if (is_last) clear_walk();
      return;
    end
    if (pos >= OffsetLimit) begin
      r.status = StatusCorrupt;
      r.payload_offset = '0;
      r.payload_type = '0;
      expected_q.push_back(r);
      if (is_last) clear_walk();
      else hdr_done = 1'b1;
      return;
    end
    pos = pos + 16'd1;
    case (st)
      WalkFlagsHi: begin
        flags = {b, 8'h00};
        st = WalkFlagsLo;
      end
      WalkFlagsLo: begin
        flags[7:0] = b;
        st = WalkTypeHi;
      end
      WalkTypeHi: begin
        ptype = {b, 8'h00};
        st = WalkTypeLo;
      end
      WalkTypeLo: begin
        ptype[7:0] = b;
        skip = option_bytes(flags);
        if (skip != 0) st = WalkSkip;
        else complete = options_finished();
      end
      WalkSkip: begin
        skip = skip - 8'd1;
        if (skip == 0) complete = options_finished();
      end
      WalkSreHead: begin
        skip = skip - 8'd1;
        if (skip == 0) st = WalkSreLen;
      end
      WalkSreLen: begin
        // zero length closes the route list
        if (b == 8'h00) complete = 1'b1;
        else begin
          skip = b;
          st = WalkSreBody;
        end
      end
      default: begin
        skip = skip - 8'd1;
        if (skip == 0) begin
          st = WalkSreHead;
          skip = 8'd3;
        end
      end
    endcase
    if (complete) begin
      r.status = StatusOk;
      r.payload_offset = pos;
      // erspan type i carries bare ethernet and gets the configured code
      r.payload_type = (ptype == TypeErspan && (flags & FlagSequence) == 0) ? eth_code : ptype;
      expected_q.push_back(r);
      if (is_last) clear_walk();
      else hdr_done = 1'b1;
    end else if (is_last) begin
      r.status = StatusCorrupt;
      r.payload_offset = '0;
      r.payload_type = '0;
      expected_q.push_back(r);
      clear_walk();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eth_code = EthCodeReset;
      clear_walk();
      expected_q.delete();
      n_fail = 0;
      pending_o <= 0;
      fails_o <= 0;
    end else begin
      if (cfg_we_i) eth_code = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.payload_offset = out_mon.payload_offset;
        got.payload_type = out_mon.payload_type;
        if (expected_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result, expected none actual status %0d offset %h type %h",
                   $time, got.status, got.payload_offset, got.payload_type);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("payload_offset", want.payload_offset, got.payload_offset);
          check_field("payload_type", want.payload_type, got.payload_type);
        end
      end
      pending_o <= expected_q.size();
      fails_o <= n_fail;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// top of the gre header parser testbench: clock, reset, packet stimulus and verdict
`timescale 1ns / 100ps
module tb_top;
  import gre_hp_pkg::*;

  localparam int RandomBytes = 1600;
  // no transfer at all for this many cycles means the block hung
  localparam int WatchLimit  = 2000;
  // long receiver hold-off, so the result register fills and input backs up
  localparam int HoldCycles  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          pending;
  int          fails;
  bit          steady;    // both sides stop idling while set
  bit          hold_req;  // asks the receiver for one long hold-off
  logic [7:0]  pkt_q[$];  // bytes of the packet being assembled
  int          route_q[$];  // lengths of source-route entries for the next packet
  int          work_bytes;  // header bytes sent, payload that the block skips not counted

  gre_hp_in_if  in_ch ();
  gre_hp_out_if out_ch ();

  gre_header_parser #(
    .OFFSET_WIDTH(16)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  gre_hp_checker #(
    .OFFSET_WIDTH(16)
  ) u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one byte transfer; a random idle gap may come first
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_pkt();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    pkt_q.delete();
  endtask

  // well-formed gre packet: flags, type, option words, route entries, payload
  task automatic build_gre(input logic [15:0] flags, input logic [15:0] ptype,
                           input int pay_len);
    bit pptp;
    int opt;
    pptp = (flags & VersionMask) == VersionPptp;
    if (pptp)
      opt = 4 + (((flags & FlagSequence) != 0) ? 4 : 0) + (((flags & FlagAck) != 0) ? 4 : 0);
    else
      opt = (((flags & (FlagChecksum | FlagRouting)) != 0) ? 4 : 0)
          + (((flags & FlagKey) != 0) ? 4 : 0) + (((flags & FlagSequence) != 0) ? 4 : 0);
    pkt_q.push_back(flags[15:8]);
    pkt_q.push_back(flags[7:0]);
    pkt_q.push_back(ptype[15:8]);
    pkt_q.push_back(ptype[7:0]);
    repeat (opt) pkt_q.push_back(8'($urandom_range(255)));
    // route walk only outside version 1, closed by a zero-length entry
    if (!pptp && (flags & FlagRouting) != 0) begin
      foreach (route_q[i]) begin
        repeat (3) pkt_q.push_back(8'($urandom_range(255)));
        pkt_q.push_back(8'(route_q[i]));
        repeat (route_q[i]) pkt_q.push_back(8'($urandom_range(255)));
      end
      repeat (3) pkt_q.push_back(8'($urandom_range(255)));
      pkt_q.push_back(8'h00);
    end
    route_q.delete();
    work_bytes += pkt_q.size();
    repeat (pay_len) pkt_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic rand_gre(input int pay_max);
    logic [15:0] flags;
    logic [15:0] ptype;
    int          r;
    flags = 16'($urandom);
    r = $urandom_range(9);
    if (r < 3) flags = (flags & ~VersionMask) | VersionPptp;
    else if (r < 7) flags = flags & ~VersionMask;
    ptype = ($urandom_range(3) == 0) ? TypeErspan : 16'($urandom);
    repeat ($urandom_range(3)) begin
      r = $urandom_range(9);
      // mostly short entries, now and then the longest one
      route_q.push_back(r < 7 ? $urandom_range(8, 1) : (r < 9 ? $urandom_range(40, 9) : 255));
    end
    build_gre(flags, ptype, $urandom_range(pay_max));
  endtask

  task automatic truncate_pkt(input int keep);
    while (pkt_q.size() > keep) void'(pkt_q.pop_back());
  endtask

  // wait until every result is in, then give the pipeline time to empty
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_eth_code(input logic [15:0] code);
    in_ch.valid <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int base;
    int pkts;
    int kind;
    int r;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'h0000;
    steady = 1'b0;
    hold_req = 1'b0;
    work_bytes = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // packets shorter than the fixed four bytes
    pkt_q.push_back(8'hff);
    send_pkt();
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'h08);
    send_pkt();
    // header ending exactly on the last byte
    build_gre(16'h0000, 16'h0000, 0);
    send_pkt();
    // erspan type i under the reset code, then with sequence so no substitution
    build_gre(16'h0000, TypeErspan, 3);
    send_pkt();
    build_gre(FlagSequence, TypeErspan, 1);
    send_pkt();
    build_gre(FlagChecksum | FlagKey | FlagSequence, 16'hffff, 2);
    send_pkt();
    // enhanced gre: call id always, sequence and ack words
    build_gre(FlagSequence | FlagAck | VersionPptp, 16'h880b, 0);
    send_pkt();
    // enhanced gre ignores the routing flag
    build_gre(FlagRouting | VersionPptp, TypeErspan, 1);
    send_pkt();
    // every flag set, version 7 takes the classic path
    route_q.push_back(3);
    build_gre(16'hffff, 16'h6558, 0);
    send_pkt();
    route_q.push_back(1);
    route_q.push_back(255);
    build_gre(FlagRouting, 16'h0800, 5);
    send_pkt();
    // packet ending inside a route entry body, and inside the option words
    route_q.push_back(6);
    build_gre(FlagRouting | FlagKey, 16'h86dd, 0);
    truncate_pkt(18);
    send_pkt();
    build_gre(FlagChecksum, 16'h0800, 0);
    truncate_pkt(6);
    send_pkt();

    // code register at both extremes
    write_eth_code(16'h0000);
    build_gre(16'h0000, TypeErspan, 0);
    send_pkt();
    write_eth_code(16'hffff);
    build_gre(FlagKey, TypeErspan, 2);
    send_pkt();

    // random packets: mostly well formed, some cut short, some noise
    base = work_bytes;
    pkts = 0;
    while (work_bytes < base + RandomBytes) begin
      if (pkts == 60) hold_req = 1'b1;
      steady = (pkts >= 100 && pkts < 160);
      if (pkts % 40 == 39) begin
        r = $urandom_range(9);
        write_eth_code(r == 0 ? 16'h0000 : (r == 1 ? 16'hffff : 16'($urandom)));
      end
      kind = $urandom_range(99);
      if (kind < 70) begin
        rand_gre(6);
      end else if (kind < 85) begin
        rand_gre(2);
        if (pkt_q.size() > 1) truncate_pkt($urandom_range(pkt_q.size() - 1, 1));
      end else begin
        r = $urandom_range(12, 1);
        repeat (r) pkt_q.push_back(8'($urandom_range(255)));
        work_bytes += r;
      end
      send_pkt();
      pkts++;
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
